@@ src/fmbs_pkg.sv @@
`timescale 1ns / 1ps
package fmbs_pkg;
  localparam int NSYM      = 5;
  localparam int SYM_W     = 3;
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 11;
  localparam int CVAL_W    = 11;
  localparam int START_W   = 11;
  localparam int MATCH_W   = 11;
  localparam int RANGE_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam int BWT_LENGTH_DEF      = 1024;
  localparam int SAMPLE_INTERVAL_DEF = 5;

  localparam logic [MODE_W-1:0] MODE_BWT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CKPT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
endpackage

@@ src/fmbs_ram.sv @@
`timescale 1ns / 1ps
module fmbs_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ src/fm_index_backward_search_count.sv @@
`timescale 1ns / 1ps
// FM-index backward search counter over a five-symbol alphabet.
// Input stream: each transfer is a BWT symbol write, a checkpoint count write or
// one query symbol; tlast marks the final symbol of a query. The first symbol of a
// query sets the row range from the start registers. Each later symbol runs the
// divide, base, issue and count steps for the low bound and then for the high
// bound; each count walks c BWT rows from the chosen checkpoint (at most half an
// interval, up to one less than an interval in the last block). One sequencer
// reads the shared single-port symbol memory, one row per count step, and the
// checkpoint memory once per bound. A final symbol then loads the result register.
// The result stream carries one transfer per query. The result register holds
// its transfer while the receiver stalls; writes and query symbols keep being
// accepted meanwhile, and only the next final symbol waits for the register.
// The configuration channel is always ready; it must be written only while idle,
// as the block does not enforce this. Reset clears the start registers, the query
// state and the output valid; the two memories hold unknown contents until written.
module fm_index_backward_search_count
  import fmbs_pkg::*;
#(
  parameter int BWT_LENGTH      = fmbs_pkg::BWT_LENGTH_DEF,
  parameter int SAMPLE_INTERVAL = fmbs_pkg::SAMPLE_INTERVAL_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // mode[1:0], address[12:2], symbol[15:13], count_value[26:16], zero fill
  input  logic [fmbs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // match_count[10:0], range_low[20:11], range_high[30:21], zero fill
  output logic [fmbs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fmbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmbs_pkg::START_W-1:0]       cfg_data
);
  localparam int ROW_W      = $clog2(BWT_LENGTH);
  localparam int LAST_BLOCK = (BWT_LENGTH - 1) / SAMPLE_INTERVAL;
  localparam int CKPT_DEPTH = (LAST_BLOCK + 1) * NSYM;
  localparam int CK_W       = $clog2(CKPT_DEPTH);
  localparam int BLK_W      = $clog2(LAST_BLOCK + 2);
  localparam int SI_W       = $clog2(SAMPLE_INTERVAL);
  localparam int SH         = ROW_W + SI_W;
  localparam int PW         = ROW_W + SH + 1;
  localparam longint RECIP  = ((64'd1 << SH) + SAMPLE_INTERVAL - 1) / SAMPLE_INTERVAL;
  localparam int CNT_W      = $clog2(SAMPLE_INTERVAL + 1);
  localparam int SW         = ((ROW_W > 12) ? ROW_W : 12) + 2;
  localparam logic signed [SW-1:0] LMAX = SW'(BWT_LENGTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_BASE   = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_COUNT  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  typedef struct packed {
    logic             ok;
    logic [ROW_W-1:0] lo;
    logic [ROW_W-1:0] hi;
  } rng_t;

  function automatic rng_t clamp_range(logic signed [SW-1:0] lo,
                                       logic signed [SW-1:0] hi);
    rng_t res;
    logic signed [SW-1:0] lo_c;
    logic signed [SW-1:0] hi_c;
    lo_c   = (lo < 0) ? '0 : lo;
    hi_c   = (hi > LMAX) ? LMAX : hi;
    res.ok = !(hi < lo) && !(hi_c < lo_c);
    res.lo = ROW_W'(lo_c);
    res.hi = ROW_W'(hi_c);
    return res;
  endfunction

  // Input fields.
  logic [MODE_W-1:0] f_mode;
  logic [ADDR_W-1:0] f_addr;
  logic [SYM_W-1:0]  f_sym;
  logic [CVAL_W-1:0] f_cnt;
  assign f_mode = in_tdata[1:0];
  assign f_addr = in_tdata[12:2];
  assign f_sym  = in_tdata[15:13];
  assign f_cnt  = in_tdata[26:16];

  logic [START_W-1:0] start_r [NSYM];
  logic [2:0]         state_r, state_nxt;
  logic [ROW_W-1:0]   cur_low_r, cur_high_r;
  logic               in_query_r, failed_r, last_r;
  logic [SYM_W-1:0]   sym_r;
  logic signed [SW-1:0] base_r, lo_r, n_r;
  logic [ROW_W-1:0]   r_r, blkbase_r, ptr_r;
  logic [PW-1:0]      prod_r;
  logic [BLK_W-1:0]   blk_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               fwd_r, first_r, pend_r, self_eq_r, high_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic               acc;
  logic               bwt_en, bwt_we, ck_en, ck_we;
  logic [ROW_W-1:0]   bwt_addr;
  logic [CK_W-1:0]    ck_addr;
  logic [SYM_W-1:0]   bwt_dout;
  logic [CVAL_W-1:0]  ck_dout;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSYM; i++) start_r[i] <= '0;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NSYM))) begin
      start_r[cfg_index] <= cfg_data;
    end
  end

  // First-symbol range from the start registers.
  logic                 sym_ok;
  logic signed [SW-1:0] fs_lo, fs_hi;
  rng_t                 fs_rng;
  always_comb begin
    sym_ok = (f_sym < SYM_W'(NSYM)) && (start_r[f_sym] != '0);
    fs_lo  = SW'(start_r[f_sym]) - SW'(1);
    fs_hi  = LMAX;
    for (int t = NSYM - 1; t >= 0; t--) begin
      if ((t > int'(f_sym)) && (start_r[t] != '0)) fs_hi = SW'(start_r[t]) - SW'(2);
    end
    fs_rng = clamp_range(fs_lo, fs_hi);
  end

  // Offset within the block and the checkpoint direction.
  logic [ROW_W-1:0] off;
  logic             fwd;
  logic [BLK_W-1:0] blk_sel;
  always_comb begin
    off     = r_r - blkbase_r;
    fwd     = (off <= ROW_W'(SAMPLE_INTERVAL / 2)) || (blk_r >= BLK_W'(LAST_BLOCK));
    blk_sel = fwd ? blk_r : blk_r + BLK_W'(1);
  end

  // Counting step.
  logic                 match, self_eq_cur;
  logic signed [SW-1:0] n_cur, n_nxt, lo_new, hi_new;
  rng_t                 ns_rng;
  always_comb begin
    match       = pend_r && (bwt_dout == sym_r);
    self_eq_cur = first_r ? (bwt_dout == sym_r) : self_eq_r;
    n_cur       = first_r ? SW'(ck_dout) : n_r;
    n_nxt       = fwd_r ? n_cur + SW'(match) : n_cur - SW'(match);
    lo_new      = base_r + n_nxt - SW'(1) + (self_eq_cur ? SW'(0) : SW'(1));
    hi_new      = base_r + n_nxt - SW'(1);
    ns_rng      = clamp_range(lo_r, hi_new);
  end

  // Memory port selection: writes while idle, reads while searching.
  always_comb begin
    bwt_en   = 1'b0;
    bwt_we   = 1'b0;
    bwt_addr = ptr_r;
    ck_en    = 1'b0;
    ck_we    = 1'b0;
    ck_addr  = CK_W'(blk_sel) * CK_W'(NSYM) + CK_W'(sym_r);
    unique case (state_r)
      S_IDLE: begin
        bwt_addr = ROW_W'(f_addr);
        ck_addr  = CK_W'(f_addr);
        if (acc && (f_mode == MODE_BWT) && (32'(f_addr) < 32'(BWT_LENGTH))) begin
          bwt_en = 1'b1;
          bwt_we = 1'b1;
        end
        if (acc && (f_mode == MODE_CKPT) && (32'(f_addr) < 32'(CKPT_DEPTH))) begin
          ck_en = 1'b1;
          ck_we = 1'b1;
        end
      end
      S_ISSUE: begin
        bwt_en   = 1'b1;
        bwt_addr = r_r;
        ck_en    = 1'b1;
      end
      S_COUNT: begin
        bwt_en = (cnt_r != '0);
      end
      S_DIV, S_BASE, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && (f_mode == MODE_QUERY)) begin
          if (in_query_r && !failed_r && sym_ok) state_nxt = S_DIV;
          else if (in_tlast) state_nxt = S_FINISH;
        end
      end
      S_DIV:   state_nxt = S_BASE;
      S_BASE:  state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_COUNT;
      S_COUNT: begin
        if (cnt_r == '0) begin
          if (!high_r) state_nxt = S_DIV;
          else state_nxt = last_r ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_low_r   <= '0;
      cur_high_r  <= '0;
      in_query_r  <= 1'b0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready && (state_r != S_FINISH)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc && (f_mode == MODE_QUERY)) begin
            last_r <= in_tlast;
            sym_r  <= f_sym;
            base_r <= SW'(start_r[f_sym]) - SW'(1);
            r_r    <= cur_low_r;
            high_r <= 1'b0;
            if (!in_query_r) begin
              in_query_r <= 1'b1;
              failed_r   <= !(sym_ok && fs_rng.ok);
              if (sym_ok && fs_rng.ok) begin
                cur_low_r  <= fs_rng.lo;
                cur_high_r <= fs_rng.hi;
              end
            end else if (!failed_r && !sym_ok) begin
              failed_r <= 1'b1;
            end
          end
        end
        S_DIV: begin
          prod_r <= PW'(r_r) * PW'(RECIP);
        end
        S_BASE: begin
          blk_r     <= prod_r[SH +: BLK_W];
          blkbase_r <= ROW_W'(prod_r[SH +: BLK_W]) * ROW_W'(SAMPLE_INTERVAL);
        end
        S_ISSUE: begin
          fwd_r   <= fwd;
          first_r <= 1'b1;
          pend_r  <= 1'b0;
          if (fwd) begin
            ptr_r <= blkbase_r + ROW_W'(1);
            cnt_r <= CNT_W'(off);
          end else begin
            ptr_r <= blkbase_r + ROW_W'(SAMPLE_INTERVAL);
            cnt_r <= CNT_W'(ROW_W'(SAMPLE_INTERVAL) - off);
          end
        end
        S_COUNT: begin
          first_r   <= 1'b0;
          n_r       <= n_nxt;
          self_eq_r <= self_eq_cur;
          if (cnt_r != '0) begin
            cnt_r  <= cnt_r - CNT_W'(1);
            ptr_r  <= fwd_r ? ptr_r + ROW_W'(1) : ptr_r - ROW_W'(1);
            pend_r <= 1'b1;
          end else if (!high_r) begin
            lo_r   <= lo_new;
            high_r <= 1'b1;
            r_r    <= cur_high_r;
          end else begin
            failed_r <= !ns_rng.ok;
            if (ns_rng.ok) begin
              cur_low_r  <= ns_rng.lo;
              cur_high_r <= ns_rng.hi;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            in_query_r  <= 1'b0;
            failed_r    <= 1'b0;
            if (failed_r) begin
              out_data_r <= '0;
            end else begin
              out_data_r <= {1'b0,
                             RANGE_W'(cur_high_r),
                             RANGE_W'(cur_low_r),
                             MATCH_W'((ROW_W + 1)'(cur_high_r) - (ROW_W + 1)'(cur_low_r)
                                      + (ROW_W + 1)'(1))};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  fmbs_ram #(.WIDTH(SYM_W), .DEPTH(BWT_LENGTH)) u_bwt (
    .clk   (clk),
    .en    (bwt_en),
    .we    (bwt_we),
    .addr  (bwt_addr),
    .wdata (f_sym),
    .rdata (bwt_dout)
  );

  fmbs_ram #(.WIDTH(CVAL_W), .DEPTH(CKPT_DEPTH)) u_ckpt (
    .clk   (clk),
    .en    (ck_en),
    .we    (ck_we),
    .addr  (ck_addr),
    .wdata (f_cnt),
    .rdata (ck_dout)
  );

  // Stores are only written while no search is reading them.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (bwt_we || ck_we) |-> (state_r == S_IDLE))
    else $error("memory write during search");

  // A live range is never empty and stays inside the table.
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_query_r && !failed_r) |-> (cur_low_r <= cur_high_r))
    else $error("current range is empty");

  a_range_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_high_r) < 32'(BWT_LENGTH))
    else $error("range beyond table");

  // Emitting a result closes the query.
  a_emit_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && (!out_valid_r || out_tready)) |=> (out_valid_r && !in_query_r))
    else $error("result emitted without closing query");
endmodule
